FILE: rtl/pcsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcsv_pkg;

	// Result codes, in the order the checks are applied
	typedef enum logic [4:0] {
		ST_OK              = 5'd0,
		ST_NOT_PNG         = 5'd1,
		ST_LEN_OVER        = 5'd2,
		ST_CRC             = 5'd3,
		ST_NO_IHDR_FIRST   = 5'd4,
		ST_IHDR_LEN        = 5'd5,
		ST_IHDR_DIM        = 5'd6,
		ST_IHDR_DEPTH      = 5'd7,
		ST_IHDR_METHOD     = 5'd8,
		ST_IHDR_DUP        = 5'd9,
		ST_PLTE_AFTER_IDAT = 5'd10,
		ST_PLTE_DUP        = 5'd11,
		ST_PLTE_LEN        = 5'd12,
		ST_IDAT_GAP        = 5'd13,
		ST_TRNS_AFTER_IDAT = 5'd14,
		ST_TRNS_NO_PLTE    = 5'd15,
		ST_IEND_LEN        = 5'd16,
		ST_MISS_IHDR       = 5'd17,
		ST_MISS_PLTE       = 5'd18,
		ST_MISS_IDAT       = 5'd19,
		ST_MISS_IEND       = 5'd20,
		ST_TRAILING        = 5'd21
	} status_t;

	typedef enum logic [1:0] {
		PH_SIG   = 2'd0,
		PH_CHUNK = 2'd1,
		PH_AFTER = 2'd2,
		PH_TRAIL = 2'd3
	} phase_t;

	// Which part of a chunk the next byte belongs to
	typedef enum logic [1:0] {
		FLD_LEN  = 2'd0,
		FLD_TYPE = 2'd1,
		FLD_DATA = 2'd2,
		FLD_CRC  = 2'd3
	} field_t;

	typedef struct packed {
		logic iend;
		logic nonidat;
		logic idat;
		logic plte;
		logic ihdr;
	} seen_t;

	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [31:0] PLTE_MAX  = 32'd768;
	localparam logic [31:0] IHDR_LEN  = 32'd13;
	localparam logic [3:0]  CNT_SAT   = 4'd12;
	localparam logic [3:0]  HDR_BYTES = 4'd13;

	localparam logic [31:0] T_IHDR = 32'h4948_4452;
	localparam logic [31:0] T_PLTE = 32'h504C_5445;
	localparam logic [31:0] T_IDAT = 32'h4944_4154;
	localparam logic [31:0] T_TRNS = 32'h7452_4E53;
	localparam logic [31:0] T_IEND = 32'h4945_4E44;

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h89;
			3'd1: r = 8'h50;
			3'd2: r = 8'h4E;
			3'd3: r = 8'h47;
			3'd4: r = 8'h0D;
			3'd5: r = 8'h0A;
			3'd6: r = 8'h1A;
			default: r = 8'h0A;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] mod3_small(input logic [3:0] v);
		logic [1:0] r;
		case (v)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
			default:                              r = 2'd2;
		endcase
		return r;
	endfunction

	// 4 == 1 mod 3, so the base-4 digit sum keeps the residue
	function automatic logic [1:0] mod3_byte(input logic [7:0] b);
		logic [3:0] s;
		s = {2'b00, b[1:0]} + {2'b00, b[3:2]} + {2'b00, b[5:4]} + {2'b00, b[7:6]};
		return mod3_small(s);
	endfunction

	function automatic logic depth_ok(input logic [7:0] ct, input logic [7:0] d);
		logic low;
		logic high;
		logic r;
		low  = d inside {8'd1, 8'd2, 8'd4};
		high = d inside {8'd8, 8'd16};
		case (ct)
			8'd0:             r = low | high;
			8'd3:             r = low | (d == 8'd8);
			8'd2, 8'd4, 8'd6: r = high;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pcsv_crc_byte.sv
`timescale 1ns / 1ps
`default_nettype none

// Reflected CRC-32 advanced by one byte, eight bit steps unrolled.
module pcsv_crc_byte (
	input  wire logic [31:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [31:0] crc_out
);
	import pcsv_pkg::*;

	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

FILE: rtl/pcsv_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-byte parser state. All state advances on step; on the last byte of a
// file the state returns to its reset values. status is the verdict the file
// would get if the current byte were its last.
module pcsv_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	output pcsv_pkg::status_t      status
);
	import pcsv_pkg::*;

	phase_t     phase_q,    phase_n;
	logic [2:0] sig_idx_q,  sig_idx_n;
	field_t     fld_q,      fld_n;
	logic [3:0] cnt_q,      cnt_n;      // chunk bytes, saturates at 12
	logic [31:0] len_q,     len_n;
	logic [1:0] lenm3_q,    lenm3_n;
	logic [31:0] type_q,    type_n;
	logic [31:0] rem_q,     rem_n;      // payload bytes still to come
	logic [3:0] hdr_k_q,    hdr_k_n;    // payload index, saturates at 13
	logic [1:0] crc_idx_q,  crc_idx_n;
	logic [31:0] crc_q,     crc_n;
	logic [31:0] stored_q,  stored_n;
	logic       nz_w_q,     nz_w_n;
	logic       nz_h_q,     nz_h_n;
	logic [7:0] depth_q,    depth_n;
	logic [7:0] ctype_q,    ctype_n;
	logic [7:0] comp_q,     comp_n;
	logic [7:0] filt_q,     filt_n;
	logic [7:0] intl_q,     intl_n;
	seen_t      seen_q,     seen_n;
	status_t    err_q,      err_n;

	logic [31:0] crc_calc;
	logic [31:0] stored_full;
	status_t     judge;

	pcsv_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (data_byte),
		.crc_out (crc_calc)
	);

	assign stored_full = {stored_q[23:0], data_byte};

	// next state
	always_comb begin
		phase_n   = phase_q;
		sig_idx_n = sig_idx_q;
		fld_n     = fld_q;
		cnt_n     = cnt_q;
		len_n     = len_q;
		lenm3_n   = lenm3_q;
		type_n    = type_q;
		rem_n     = rem_q;
		hdr_k_n   = hdr_k_q;
		crc_idx_n = crc_idx_q;
		crc_n     = crc_q;
		stored_n  = stored_q;
		nz_w_n    = nz_w_q;
		nz_h_n    = nz_h_q;
		depth_n   = depth_q;
		ctype_n   = ctype_q;
		comp_n    = comp_q;
		filt_n    = filt_q;
		intl_n    = intl_q;
		seen_n    = seen_q;
		err_n     = err_q;
		judge     = ST_OK;

		if (err_q == ST_OK) begin
			case (phase_q)
				PH_SIG: begin
					if (data_byte != sig_byte(sig_idx_q))
						err_n = ST_NOT_PNG;
					sig_idx_n = sig_idx_q + 3'd1;
					if (sig_idx_q == 3'd7)
						phase_n = PH_CHUNK;
				end
				PH_CHUNK: begin
					if (cnt_q != CNT_SAT)
						cnt_n = cnt_q + 4'd1;
					case (fld_q)
						FLD_LEN: begin
							len_n   = {len_q[23:0], data_byte};
							lenm3_n = mod3_small({2'b00, lenm3_q} + {2'b00, mod3_byte(data_byte)});
							if (cnt_q == 4'd3)
								fld_n = FLD_TYPE;
						end
						FLD_TYPE: begin
							type_n = {type_q[23:0], data_byte};
							crc_n  = crc_calc;
							if (cnt_q == 4'd7) begin
								rem_n = len_q;
								fld_n = (len_q == 32'd0) ? FLD_CRC : FLD_DATA;
							end
						end
						FLD_DATA: begin
							crc_n = crc_calc;
							rem_n = rem_q - 32'd1;
							if (rem_q == 32'd1)
								fld_n = FLD_CRC;
							if (hdr_k_q != HDR_BYTES)
								hdr_k_n = hdr_k_q + 4'd1;
							if (!seen_q.ihdr && hdr_k_q < HDR_BYTES) begin
								if (hdr_k_q < 4'd4) begin
									if (data_byte != 8'd0) nz_w_n = 1'b1;
								end else if (hdr_k_q < 4'd8) begin
									if (data_byte != 8'd0) nz_h_n = 1'b1;
								end else begin
									case (hdr_k_q)
										4'd8:    depth_n = data_byte;
										4'd9:    ctype_n = data_byte;
										4'd10:   comp_n  = data_byte;
										4'd11:   filt_n  = data_byte;
										default: intl_n  = data_byte;
									endcase
								end
							end
						end
						default: begin
							stored_n  = stored_full;
							crc_idx_n = crc_idx_q + 2'd1;
							if (crc_idx_q == 2'd3) begin
								// whole chunk in: judge it
								if ((crc_q ^ CRC_INIT) != stored_full) begin
									judge = ST_CRC;
								end else if (!seen_q.ihdr) begin
									if (type_q != T_IHDR)
										judge = ST_NO_IHDR_FIRST;
									else if (len_q != IHDR_LEN)
										judge = ST_IHDR_LEN;
									else if (!(nz_w_q && nz_h_q))
										judge = ST_IHDR_DIM;
									else if (!depth_ok(ctype_q, depth_q))
										judge = ST_IHDR_DEPTH;
									else if (comp_q != 8'd0 || filt_q != 8'd0 || intl_q > 8'd1)
										judge = ST_IHDR_METHOD;
									else
										seen_n.ihdr = 1'b1;
								end else if (type_q == T_IHDR) begin
									judge = ST_IHDR_DUP;
								end else if (type_q == T_PLTE) begin
									if (seen_q.idat)
										judge = ST_PLTE_AFTER_IDAT;
									else if (seen_q.plte)
										judge = ST_PLTE_DUP;
									else if (len_q == 32'd0 || lenm3_q != 2'd0 || len_q > PLTE_MAX)
										judge = ST_PLTE_LEN;
									else
										seen_n.plte = 1'b1;
								end else if (type_q == T_IDAT) begin
									if (seen_q.nonidat)
										judge = ST_IDAT_GAP;
									else
										seen_n.idat = 1'b1;
								end else if (type_q == T_TRNS) begin
									if (seen_q.idat)
										judge = ST_TRNS_AFTER_IDAT;
									else if (ctype_q == 8'd3 && !seen_q.plte)
										judge = ST_TRNS_NO_PLTE;
								end else if (type_q == T_IEND) begin
									if (len_q != 32'd0) begin
										judge = ST_IEND_LEN;
									end else begin
										seen_n.iend = 1'b1;
										phase_n     = PH_AFTER;
									end
								end else if (seen_q.idat) begin
									seen_n.nonidat = 1'b1;
								end
								err_n     = judge;
								fld_n     = FLD_LEN;
								cnt_n     = 4'd0;
								len_n     = 32'd0;
								lenm3_n   = 2'd0;
								type_n    = 32'd0;
								hdr_k_n   = 4'd0;
								crc_idx_n = 2'd0;
								crc_n     = CRC_INIT;
								stored_n  = 32'd0;
							end
						end
					endcase
				end
				default: phase_n = PH_TRAIL;
			endcase
		end
	end

	// verdict as of this byte
	always_comb begin
		if (err_n != ST_OK)
			status = err_n;
		else if (phase_n == PH_SIG)
			status = ST_NOT_PNG;
		else if (phase_n == PH_CHUNK && cnt_n >= CNT_SAT)
			status = ST_LEN_OVER;
		else if (!seen_n.ihdr)
			status = ST_MISS_IHDR;
		else if (ctype_n == 8'd3 && !seen_n.plte)
			status = ST_MISS_PLTE;
		else if (!seen_n.idat)
			status = ST_MISS_IDAT;
		else if (!seen_n.iend)
			status = ST_MISS_IEND;
		else if (phase_n == PH_TRAIL)
			status = ST_TRAILING;
		else
			status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIG;
			sig_idx_q <= 3'd0;
			fld_q     <= FLD_LEN;
			cnt_q     <= 4'd0;
			len_q     <= 32'd0;
			lenm3_q   <= 2'd0;
			type_q    <= 32'd0;
			rem_q     <= 32'd0;
			hdr_k_q   <= 4'd0;
			crc_idx_q <= 2'd0;
			crc_q     <= CRC_INIT;
			stored_q  <= 32'd0;
			nz_w_q    <= 1'b0;
			nz_h_q    <= 1'b0;
			depth_q   <= 8'd0;
			ctype_q   <= 8'd0;
			comp_q    <= 8'd0;
			filt_q    <= 8'd0;
			intl_q    <= 8'd0;
			seen_q    <= '0;
			err_q     <= ST_OK;
		end else if (step && last_byte) begin
			// file done: back to the start state for the next one
			phase_q   <= PH_SIG;
			sig_idx_q <= 3'd0;
			fld_q     <= FLD_LEN;
			cnt_q     <= 4'd0;
			len_q     <= 32'd0;
			lenm3_q   <= 2'd0;
			type_q    <= 32'd0;
			rem_q     <= 32'd0;
			hdr_k_q   <= 4'd0;
			crc_idx_q <= 2'd0;
			crc_q     <= CRC_INIT;
			stored_q  <= 32'd0;
			nz_w_q    <= 1'b0;
			nz_h_q    <= 1'b0;
			depth_q   <= 8'd0;
			ctype_q   <= 8'd0;
			comp_q    <= 8'd0;
			filt_q    <= 8'd0;
			intl_q    <= 8'd0;
			seen_q    <= '0;
			err_q     <= ST_OK;
		end else if (step) begin
			phase_q   <= phase_n;
			sig_idx_q <= sig_idx_n;
			fld_q     <= fld_n;
			cnt_q     <= cnt_n;
			len_q     <= len_n;
			lenm3_q   <= lenm3_n;
			type_q    <= type_n;
			rem_q     <= rem_n;
			hdr_k_q   <= hdr_k_n;
			crc_idx_q <= crc_idx_n;
			crc_q     <= crc_n;
			stored_q  <= stored_n;
			nz_w_q    <= nz_w_n;
			nz_h_q    <= nz_h_n;
			depth_q   <= depth_n;
			ctype_q   <= ctype_n;
			comp_q    <= comp_n;
			filt_q    <= filt_n;
			intl_q    <= intl_n;
			seen_q    <= seen_n;
			err_q     <= err_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/png_chunk_stream_validator.sv
`timescale 1ns / 1ps
`default_nettype none

// PNG chunk stream validator. Feed a PNG file one byte per transaction on the
// slave stream, with s_tlast on its final byte; exactly one verdict comes out
// on the master stream after that byte, and the block is then ready for the
// next file with no gap. The block checks the 8-byte signature, runs CRC-32
// over every chunk's type and payload against the stored CRC, and applies the
// IHDR/PLTE/IDAT/tRNS/IEND ordering and header rules; the first failure is
// kept and reported (status 0 means the file is valid, 1 means not a PNG).
// Throughput is one byte per clock, except when a final byte is held back as told
// below: each byte is registered in the input register and then folded into the
// parser state, the byte-wide CRC update being the longest path. A verdict appears
// on m_tvalid in the cycle after the final byte enters the core; while a verdict waits for
// m_tready, non-final bytes keep flowing and only a second final byte stalls.
module png_chunk_stream_validator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata    // [4:0] status, [5] is_png, [6] valid_res, [7] zero
);
	import pcsv_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	status_t    status_nxt;
	logic [7:0] m_tdata_q;
	logic       m_tvalid_q;

	// byte leaves the input register unless it is final and the output slot is busy
	assign advance  = valid_s1 && (!last_s1 || !m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	pcsv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.status    (status_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			m_tdata_q <= {1'b0, status_nxt == ST_OK, status_nxt != ST_NOT_PNG, status_nxt};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

FILE: rtl/pcsv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pcsv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);
	import pcsv_pkg::*;

	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6] == (m_tdata[4:0] == ST_OK)))
		else $error("valid_res disagrees with status");

	a_png_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5] == (m_tdata[4:0] != ST_NOT_PNG)))
		else $error("is_png disagrees with status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:0] <= ST_TRAILING && !m_tdata[7]))
		else $error("status code out of range");

	a_ready_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> s_tready)
		else $error("input not ready after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind png_chunk_stream_validator pcsv_checker u_pcsv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
